>>> sv/ucw_pkg.sv
// Package: shared types, register indexes and interval tables for the cell width classifier.
`default_nettype none
package ucw_pkg;

   localparam int unsigned CpWidth  = 21;
   localparam int unsigned CsrIdxW  = 3;
   localparam int unsigned CsrDataW = 2;

   typedef logic [CpWidth-1:0] cp_type;
   typedef logic signed [2:0]  width_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_COMBINING_WIDTH = 3'd0,
      CSR_FULL_WIDTH_EN   = 3'd1,
      CSR_AMBIG_WIDE      = 3'd2,
      CSR_BMP_ONLY        = 3'd3,
      CSR_NEWER_CONSOLE   = 3'd4
   } csr_idx_type;

   // configuration registers as seen by the datapath
   typedef struct packed {
      logic [1:0] combining_width;
      logic       full_width_enable;
      logic       ambiguous_wide_mode;
      logic       bmp_only_mode;
      logic       newer_console_flag;
   } cfg_type;

   // interval-match flags produced by the classify stage
   typedef struct packed {
      logic eaa;
      logic zero_width;
      logic half_exc;
   } match_type;

   localparam width_type W_CTRL = -3'sd1;
   localparam width_type W_ZERO = 3'sd0;
   localparam width_type W_ONE  = 3'sd1;
   localparam width_type W_TWO  = 3'sd2;

   localparam int unsigned NumZw  = 143;
   localparam int unsigned NumEaa = 156;

   localparam logic [NumZw*42-1:0] ZwTable = {
      21'h00300,21'h0036F,21'h00483,21'h00486,21'h00488,21'h00489,21'h00591,21'h005BD,
      21'h005BF,21'h005BF,21'h005C1,21'h005C2,21'h005C4,21'h005C5,21'h005C7,21'h005C7,
      21'h00600,21'h00603,21'h00610,21'h00615,21'h0064B,21'h0065E,21'h00670,21'h00670,
      21'h006D6,21'h006E4,21'h006E7,21'h006E8,21'h006EA,21'h006ED,21'h0070F,21'h0070F,
      21'h00711,21'h00711,21'h00730,21'h0074A,21'h007A6,21'h007B0,21'h007EB,21'h007F3,
      21'h00901,21'h00902,21'h0093C,21'h0093C,21'h00941,21'h00948,21'h0094D,21'h0094D,
      21'h00951,21'h00954,21'h00962,21'h00963,21'h00981,21'h00981,21'h009BC,21'h009BC,
      21'h009C1,21'h009C4,21'h009CD,21'h009CD,21'h009E2,21'h009E3,21'h00A01,21'h00A02,
      21'h00A3C,21'h00A3C,21'h00A41,21'h00A42,21'h00A47,21'h00A48,21'h00A4B,21'h00A4D,
      21'h00A70,21'h00A71,21'h00A81,21'h00A82,21'h00ABC,21'h00ABC,21'h00AC1,21'h00AC5,
      21'h00AC7,21'h00AC8,21'h00ACD,21'h00ACD,21'h00AE2,21'h00AE3,21'h00B01,21'h00B01,
      21'h00B3C,21'h00B3C,21'h00B3F,21'h00B3F,21'h00B41,21'h00B43,21'h00B4D,21'h00B4D,
      21'h00B56,21'h00B56,21'h00B82,21'h00B82,21'h00BC0,21'h00BC0,21'h00BCD,21'h00BCD,
      21'h00C3E,21'h00C40,21'h00C46,21'h00C48,21'h00C4A,21'h00C4D,21'h00C55,21'h00C56,
      21'h00CBC,21'h00CBC,21'h00CBF,21'h00CBF,21'h00CC6,21'h00CC6,21'h00CCC,21'h00CCD,
      21'h00CE2,21'h00CE3,21'h00D41,21'h00D43,21'h00D4D,21'h00D4D,21'h00DCA,21'h00DCA,
      21'h00DD2,21'h00DD4,21'h00DD6,21'h00DD6,21'h00E31,21'h00E31,21'h00E34,21'h00E3A,
      21'h00E47,21'h00E4E,21'h00EB1,21'h00EB1,21'h00EB4,21'h00EB9,21'h00EBB,21'h00EBC,
      21'h00EC8,21'h00ECD,21'h00F18,21'h00F19,21'h00F35,21'h00F35,21'h00F37,21'h00F37,
      21'h00F39,21'h00F39,21'h00F71,21'h00F7E,21'h00F80,21'h00F84,21'h00F86,21'h00F87,
      21'h00F90,21'h00F97,21'h00F99,21'h00FBC,21'h00FC6,21'h00FC6,21'h0102D,21'h01030,
      21'h01032,21'h01032,21'h01036,21'h01037,21'h01039,21'h01039,21'h01058,21'h01059,
      21'h01160,21'h011FF,21'h0135F,21'h0135F,21'h01712,21'h01714,21'h01732,21'h01734,
      21'h01752,21'h01753,21'h01772,21'h01773,21'h017B4,21'h017B5,21'h017B7,21'h017BD,
      21'h017C6,21'h017C6,21'h017C9,21'h017D3,21'h017DD,21'h017DD,21'h0180B,21'h0180D,
      21'h018A9,21'h018A9,21'h01920,21'h01922,21'h01927,21'h01928,21'h01932,21'h01932,
      21'h01939,21'h0193B,21'h01A17,21'h01A18,21'h01B00,21'h01B03,21'h01B34,21'h01B34,
      21'h01B36,21'h01B3A,21'h01B3C,21'h01B3C,21'h01B42,21'h01B42,21'h01B6B,21'h01B73,
      21'h01DC0,21'h01DCA,21'h01DFE,21'h01DFF,21'h0200B,21'h0200F,21'h0202A,21'h0202E,
      21'h02060,21'h02063,21'h0206A,21'h0206F,21'h020D0,21'h020EF,21'h0302A,21'h0302F,
      21'h03099,21'h0309A,21'h0A806,21'h0A806,21'h0A80B,21'h0A80B,21'h0A825,21'h0A826,
      21'h0FB1E,21'h0FB1E,21'h0FE00,21'h0FE0F,21'h0FE20,21'h0FE23,21'h0FEFF,21'h0FEFF,
      21'h0FFF9,21'h0FFFB,21'h10A01,21'h10A03,21'h10A05,21'h10A06,21'h10A0C,21'h10A0F,
      21'h10A38,21'h10A3A,21'h10A3F,21'h10A3F,21'h1D167,21'h1D169,21'h1D173,21'h1D182,
      21'h1D185,21'h1D18B,21'h1D1AA,21'h1D1AD,21'h1D242,21'h1D244,21'h1F3FB,21'h1F3FF,
      21'hE0001,21'hE0001,21'hE0020,21'hE007F,21'hE0100,21'hE01EF
   };

   localparam logic [NumEaa*42-1:0] EaaTable = {
      21'h000A1,21'h000A1,21'h000A4,21'h000A4,21'h000A7,21'h000A8,21'h000AA,21'h000AA,
      21'h000AE,21'h000AE,21'h000B0,21'h000B4,21'h000B6,21'h000BA,21'h000BC,21'h000BF,
      21'h000C6,21'h000C6,21'h000D0,21'h000D0,21'h000D7,21'h000D8,21'h000DE,21'h000E1,
      21'h000E6,21'h000E6,21'h000E8,21'h000EA,21'h000EC,21'h000ED,21'h000F0,21'h000F0,
      21'h000F2,21'h000F3,21'h000F7,21'h000FA,21'h000FC,21'h000FC,21'h000FE,21'h000FE,
      21'h00101,21'h00101,21'h00111,21'h00111,21'h00113,21'h00113,21'h0011B,21'h0011B,
      21'h00126,21'h00127,21'h0012B,21'h0012B,21'h00131,21'h00133,21'h00138,21'h00138,
      21'h0013F,21'h00142,21'h00144,21'h00144,21'h00148,21'h0014B,21'h0014D,21'h0014D,
      21'h00152,21'h00153,21'h00166,21'h00167,21'h0016B,21'h0016B,21'h001CE,21'h001CE,
      21'h001D0,21'h001D0,21'h001D2,21'h001D2,21'h001D4,21'h001D4,21'h001D6,21'h001D6,
      21'h001D8,21'h001D8,21'h001DA,21'h001DA,21'h001DC,21'h001DC,21'h00251,21'h00251,
      21'h00261,21'h00261,21'h002C4,21'h002C4,21'h002C7,21'h002C7,21'h002C9,21'h002CB,
      21'h002CD,21'h002CD,21'h002D0,21'h002D0,21'h002D8,21'h002DB,21'h002DD,21'h002DD,
      21'h002DF,21'h002DF,21'h00391,21'h003A1,21'h003A3,21'h003A9,21'h003B1,21'h003C1,
      21'h003C3,21'h003C9,21'h00401,21'h00401,21'h00410,21'h0044F,21'h00451,21'h00451,
      21'h02010,21'h02010,21'h02013,21'h02016,21'h02018,21'h02019,21'h0201C,21'h0201D,
      21'h02020,21'h02022,21'h02024,21'h02027,21'h02030,21'h02030,21'h02032,21'h02033,
      21'h02035,21'h02035,21'h0203B,21'h0203B,21'h0203E,21'h0203E,21'h02074,21'h02074,
      21'h0207F,21'h0207F,21'h02081,21'h02084,21'h020AC,21'h020AC,21'h02103,21'h02103,
      21'h02105,21'h02105,21'h02109,21'h02109,21'h02113,21'h02113,21'h02116,21'h02116,
      21'h02121,21'h02122,21'h02126,21'h02126,21'h0212B,21'h0212B,21'h02153,21'h02154,
      21'h0215B,21'h0215E,21'h02160,21'h0216B,21'h02170,21'h02179,21'h02190,21'h02199,
      21'h021B8,21'h021B9,21'h021D2,21'h021D2,21'h021D4,21'h021D4,21'h021E7,21'h021E7,
      21'h02200,21'h02200,21'h02202,21'h02203,21'h02207,21'h02208,21'h0220B,21'h0220B,
      21'h0220F,21'h0220F,21'h02211,21'h02211,21'h02215,21'h02215,21'h0221A,21'h0221A,
      21'h0221D,21'h02220,21'h02223,21'h02223,21'h02225,21'h02225,21'h02227,21'h0222C,
      21'h0222E,21'h0222E,21'h02234,21'h02237,21'h0223C,21'h0223D,21'h02248,21'h02248,
      21'h0224C,21'h0224C,21'h02252,21'h02252,21'h02260,21'h02261,21'h02264,21'h02267,
      21'h0226A,21'h0226B,21'h0226E,21'h0226F,21'h02282,21'h02283,21'h02286,21'h02287,
      21'h02295,21'h02295,21'h02299,21'h02299,21'h022A5,21'h022A5,21'h022BF,21'h022BF,
      21'h02312,21'h02312,21'h02460,21'h024E9,21'h024EB,21'h0254B,21'h02550,21'h02573,
      21'h02580,21'h0258F,21'h02592,21'h02595,21'h025A0,21'h025A1,21'h025A3,21'h025A9,
      21'h025B2,21'h025B3,21'h025B6,21'h025B7,21'h025BC,21'h025BD,21'h025C0,21'h025C1,
      21'h025C6,21'h025C8,21'h025CB,21'h025CB,21'h025CE,21'h025D1,21'h025E2,21'h025E5,
      21'h025EF,21'h025EF,21'h02605,21'h02606,21'h02609,21'h02609,21'h0260E,21'h0260F,
      21'h02614,21'h02615,21'h0261C,21'h0261C,21'h0261E,21'h0261E,21'h02640,21'h02640,
      21'h02642,21'h02642,21'h02660,21'h02661,21'h02663,21'h02665,21'h02667,21'h0266A,
      21'h0266C,21'h0266D,21'h0266F,21'h0266F,21'h0273D,21'h0273D,21'h02776,21'h0277F,
      21'h0E000,21'h0F8FF,21'h0FFFD,21'h0FFFD,21'h0F0000,21'h0FFFFD,21'h100000,21'h10FFFD
   };

   // true when cp falls in [lo, hi]
   function automatic logic in_span(input cp_type cp, input cp_type lo, input cp_type hi);
      in_span = (cp >= lo) && (cp <= hi);
   endfunction

   // parallel compare against all zero-width intervals
   function automatic logic in_zero_width(input cp_type cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NumZw; i++) begin
         hit = hit | in_span(cp, ZwTable[(NumZw-1-i)*42+21 +: 21],
                             ZwTable[(NumZw-1-i)*42 +: 21]);
      end
      in_zero_width = hit;
   endfunction

   // parallel compare against all ambiguous intervals
   function automatic logic in_ambiguous(input cp_type cp);
      logic hit;
      hit = 1'b0;
      for (int i = 0; i < NumEaa; i++) begin
         hit = hit | in_span(cp, EaaTable[(NumEaa-1-i)*42+21 +: 21],
                             EaaTable[(NumEaa-1-i)*42 +: 21]);
      end
      in_ambiguous = hit;
   endfunction

endpackage
`default_nettype wire

>>> sv/ucw_cfg_regs.sv
// Configuration register file for the cell width classifier.
`default_nettype none
module ucw_cfg_regs (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write_enable,
   input  wire logic [ucw_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [ucw_pkg::CsrDataW-1:0]  csr_write_data,
   output ucw_pkg::cfg_type                   cfg
);
   ucw_pkg::cfg_type cfg_ff, cfg_in;

   // decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (ucw_pkg::csr_idx_type'(csr_index))
            ucw_pkg::CSR_COMBINING_WIDTH: cfg_in.combining_width     = csr_write_data;
            ucw_pkg::CSR_FULL_WIDTH_EN:   cfg_in.full_width_enable   = csr_write_data[0];
            ucw_pkg::CSR_AMBIG_WIDE:      cfg_in.ambiguous_wide_mode = csr_write_data[0];
            ucw_pkg::CSR_BMP_ONLY:        cfg_in.bmp_only_mode       = csr_write_data[0];
            ucw_pkg::CSR_NEWER_CONSOLE:   cfg_in.newer_console_flag  = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{combining_width: 2'd0, full_width_enable: 1'b1,
                     ambiguous_wide_mode: 1'b0, bmp_only_mode: 1'b0,
                     newer_console_flag: 1'b0};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;
endmodule
`default_nettype wire

>>> sv/ucw_classify.sv
// Combinational width decision from a registered code point and configuration.
`default_nettype none
module ucw_classify (
   input  wire ucw_pkg::cp_type   code_point,
   input  wire ucw_pkg::cfg_type  cfg,
   output ucw_pkg::width_type     cell_width
);
   ucw_pkg::match_type m;
   ucw_pkg::cp_type    cp;
   logic               fw_forms;

   assign cp = code_point;

   // interval table matches
   always_comb begin
      m.eaa        = ucw_pkg::in_ambiguous(cp);
      m.zero_width = ucw_pkg::in_zero_width(cp);
      m.half_exc   = (cp == 21'h0303F) || ucw_pkg::in_span(cp, 21'h03248, 21'h0324F) ||
                     ucw_pkg::in_span(cp, 21'h04DC0, 21'h04DFF);
   end

   assign fw_forms = ucw_pkg::in_span(cp, 21'h0FF00, 21'h0FF60) ||
                     ucw_pkg::in_span(cp, 21'h0FFE0, 21'h0FFE6);

   // rule chain in priority order
   always_comb begin
      priority if (cfg.ambiguous_wide_mode && m.eaa)       cell_width = ucw_pkg::W_TWO;
      else if (cp == '0)                                    cell_width = ucw_pkg::W_ZERO;
      else if (cp < 21'h20)                                 cell_width = ucw_pkg::W_CTRL;
      else if (cp <= 21'h7E)                                cell_width = ucw_pkg::W_ONE;
      else if (cp < 21'hA0)                                 cell_width = ucw_pkg::W_CTRL;
      else if (m.zero_width)
         cell_width = (cfg.combining_width == 2'd3) ? ucw_pkg::W_TWO
                      : ucw_pkg::width_type'({1'b0, cfg.combining_width});
      else if (cp < 21'h1100 || !cfg.full_width_enable)     cell_width = ucw_pkg::W_ONE;
      else if (cp <= 21'h115F)                              cell_width = ucw_pkg::W_TWO;
      else if (cp == 21'h2329 || cp == 21'h232A)            cell_width = ucw_pkg::W_TWO;
      else if (ucw_pkg::in_span(cp, 21'h2E80, 21'hA4CF) ||
               ucw_pkg::in_span(cp, 21'hAC00, 21'hD7A3))
         cell_width = m.half_exc ? ucw_pkg::W_ONE : ucw_pkg::W_TWO;
      else if (ucw_pkg::in_span(cp, 21'hF900, 21'hFAFF) ||
               ucw_pkg::in_span(cp, 21'hFE10, 21'hFE19) ||
               ucw_pkg::in_span(cp, 21'hFE30, 21'hFE6F))    cell_width = ucw_pkg::W_TWO;
      else if (fw_forms)
         cell_width = (!cfg.bmp_only_mode || cfg.newer_console_flag) ? ucw_pkg::W_TWO
                      : ucw_pkg::W_ONE;
      else if (cfg.bmp_only_mode)
         cell_width = (cp >= 21'h10000) ? ucw_pkg::W_TWO : ucw_pkg::W_ONE;
      else if (ucw_pkg::in_span(cp, 21'h20000, 21'h2FFFD) ||
               ucw_pkg::in_span(cp, 21'h30000, 21'h3FFFD))  cell_width = ucw_pkg::W_TWO;
      else                                                  cell_width = ucw_pkg::W_ONE;
   end
endmodule
`default_nettype wire

>>> sv/unicode_cell_width_classifier_unit.sv
// Top level: input register, width classification and output register.
// A request passes through the input register and then the result register before its response is valid.
// Throughput: one transaction per cycle while rsp_ready is high; the two register stages act as an elastic pipe.
// A stalled response holds the result register; input accepted when its stage moves.
// Reset (synchronous, active high) empties both stages and loads register defaults:
// combining width 0, wide handling on, ambiguous/UCS-2/console flags off.
`default_nettype none
module unicode_cell_width_classifier_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [20:0]                   req_code_point,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic signed [2:0]                  rsp_cell_width,
   input  wire logic                          csr_write_enable,
   input  wire logic [ucw_pkg::CsrIdxW-1:0]   csr_index,
   input  wire logic [ucw_pkg::CsrDataW-1:0]  csr_write_data
);
   ucw_pkg::cfg_type   cfg;
   ucw_pkg::width_type width_calc;
   ucw_pkg::cp_type    cp_ff;
   ucw_pkg::width_type width_ff;
   logic               s1_valid_ff, s2_valid_ff;
   logic               s2_ready, s1_ready;

   ucw_cfg_regs u_cfg (
      .clock, .reset, .csr_write_enable, .csr_index, .csr_write_data, .cfg
   );

   ucw_classify u_cls (.code_point(cp_ff), .cfg(cfg), .cell_width(width_calc));

   // stage handshakes
   assign s2_ready  = !s2_valid_ff || rsp_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (s1_ready) s1_valid_ff <= req_valid;
         if (s2_ready) s2_valid_ff <= s1_valid_ff;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (s1_ready && req_valid) cp_ff <= req_code_point;
      if (s2_ready && s1_valid_ff) width_ff <= width_calc;
   end

   assign rsp_valid      = s2_valid_ff;
   assign rsp_cell_width = width_ff;

   // a held response keeps its value
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_width))
      else $error("response changed while stalled");
   // accepted request reaches stage one
   a_s1: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_valid_ff)
      else $error("accepted request lost");
   // result stays within -1 to 2 and never reports the unused codes -2, -3, -4 or 3
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cell_width != -3'sd2 && rsp_cell_width != 3'sd3 &&
                    rsp_cell_width != -3'sd3 && rsp_cell_width != -3'sd4)
      else $error("width out of range");
endmodule
`default_nettype wire
